// ===== rtl/ptc_pkg.sv =====
package ptc_pkg;

  // Port field widths.
  localparam int RawW     = 24;
  localparam int CoefW    = 16;
  localparam int PressW   = 21;
  localparam int TempW    = 18;
  localparam int CfgIdxW  = 3;
  localparam int InDataW  = 48;
  localparam int OutDataW = 40;

  // Internal datapath widths, sized to the worst-case calibration words.
  localparam int DtW    = 25;  // raw temperature minus reference
  localparam int MulW   = 42;  // coefficient times dt
  localparam int DtSqW  = 48;  // dt squared, never negative
  localparam int SensW  = 35;  // first-order sensitivity
  localparam int OffW   = 36;  // first-order offset
  localparam int DevW   = 18;  // temperature minus 20 C
  localparam int ColdW  = 19;  // temperature plus 15 C
  localparam int TiW    = 17;  // second-order temperature term
  localparam int SqW    = 35;  // squares of the deviations
  localparam int CorrW  = 38;  // second-order offset and sensitivity terms
  localparam int Off2W  = 40;
  localparam int Sens2W = 40;
  localparam int SplitW = 20;  // low slice of the split pressure multiply
  localparam int ProdW  = 64;
  localparam int QuotW  = 43;
  localparam int DiffW  = 44;

  localparam int TempBase = 2000;
  localparam int DevCold  = -3500;  // -15 C expressed as deviation from 20 C
  localparam int ColdBias = 3500;

  localparam longint PressMinL = -(longint'(1) <<< (PressW - 1));
  localparam longint PressMaxL = (longint'(1) <<< (PressW - 1)) - 1;
  localparam longint TempMinL  = -(longint'(1) <<< (TempW - 1));
  localparam longint TempMaxL  = (longint'(1) <<< (TempW - 1)) - 1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SENS_BASE   = 3'd0,
    REG_OFFSET_BASE = 3'd1,
    REG_SENS_TEMP   = 3'd2,
    REG_OFFSET_TEMP = 3'd3,
    REG_REF_TEMP    = 3'd4,
    REG_TEMP_SLOPE  = 3'd5
  } ptc_reg_t;

  typedef struct packed {
    logic [CoefW-1:0] sens_base;
    logic [CoefW-1:0] offset_base;
    logic [CoefW-1:0] sens_temp;
    logic [CoefW-1:0] offset_temp;
    logic [CoefW-1:0] reference_temp;
    logic [CoefW-1:0] temp_slope;
  } ptc_coeff_t;

  // Hand-off from the compensation half to the pressure scaling half.
  typedef struct packed {
    logic signed [Off2W-1:0]  off2;
    logic signed [Sens2W-1:0] sens2;
    logic [RawW-1:0]          pressure_raw;
    logic signed [TempW-1:0]  temp;
  } ptc_mid_t;

endpackage

// ===== rtl/ptc_cfg_regs.sv =====
module ptc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ptc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [ptc_pkg::CoefW-1:0]     cfg_data,
  output ptc_pkg::ptc_coeff_t           coeff
);
  import ptc_pkg::*;

  ptc_coeff_t coeff_r, coeff_nxt;

  assign cfg_ready = 1'b1;
  assign coeff     = coeff_r;

  always_comb begin
    coeff_nxt = coeff_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_SENS_BASE:   coeff_nxt.sens_base      = cfg_data;
        REG_OFFSET_BASE: coeff_nxt.offset_base    = cfg_data;
        REG_SENS_TEMP:   coeff_nxt.sens_temp      = cfg_data;
        REG_OFFSET_TEMP: coeff_nxt.offset_temp    = cfg_data;
        REG_REF_TEMP:    coeff_nxt.reference_temp = cfg_data;
        REG_TEMP_SLOPE:  coeff_nxt.temp_slope     = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r <= '0;
    end else begin
      coeff_r <= coeff_nxt;
    end
  end

endmodule

// ===== rtl/ptc_comp_front.sv =====
module ptc_comp_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ptc_pkg::ptc_coeff_t        coeff,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ptc_pkg::RawW-1:0]   pressure_raw,
  input  logic [ptc_pkg::RawW-1:0]   temperature_raw,
  output logic                       mid_valid,
  input  logic                       mid_ready,
  output ptc_pkg::ptc_mid_t          mid
);
  import ptc_pkg::*;

  localparam int Stages = 6;

  logic [Stages-1:0] v_r;
  logic [Stages-1:0] en;

  // A stage may load when it is empty or when the stage after it loads.
  always_comb begin
    en[Stages-1] = ~v_r[Stages-1] | mid_ready;
    for (int k = Stages - 2; k >= 0; k--) begin
      en[k] = ~v_r[k] | en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= (v_r & ~en) | ({v_r[Stages-2:0], in_valid} & en);
    end
  end

  assign in_ready  = en[0];
  assign mid_valid = v_r[Stages-1];

  // Stage A: offset from the reference temperature.
  logic [RawW-1:0]        a_d1_r;
  logic signed [DtW-1:0]  a_dt_r, a_dt_nxt;

  assign a_dt_nxt = $signed({1'b0, temperature_raw})
                  - $signed({1'b0, coeff.reference_temp, 8'h00});

  // Stage B: the four products of dt.
  logic [RawW-1:0]         b_d1_r;
  logic signed [MulW-1:0]  b_pc3_r, b_pc4_r, b_pc6_r;
  logic signed [MulW-1:0]  b_pc3_nxt, b_pc4_nxt, b_pc6_nxt;
  logic signed [2*DtW-1:0] b_dtsq_full;
  logic [DtSqW-1:0]        b_dtsq_r;

  assign b_pc3_nxt   = $signed({1'b0, coeff.sens_temp}) * a_dt_r;
  assign b_pc4_nxt   = $signed({1'b0, coeff.offset_temp}) * a_dt_r;
  assign b_pc6_nxt   = a_dt_r * $signed({1'b0, coeff.temp_slope});
  assign b_dtsq_full = a_dt_r * a_dt_r;

  // Stage C: first-order terms, band selection and the temperature square term.
  logic [RawW-1:0]          c_d1_r;
  logic signed [MulW-1:0]   c_sens_sh, c_off_sh, c_dev_sh;
  logic signed [SensW-1:0]  c_sens_r, c_sens_nxt;
  logic signed [OffW-1:0]   c_off_r, c_off_nxt;
  logic signed [DevW-1:0]   c_dev_r, c_dev_nxt;
  logic signed [ColdW-1:0]  c_cold_r, c_cold_nxt;
  logic                     c_low_r, c_low_nxt;
  logic                     c_cold_band_r, c_cold_band_nxt;
  logic [DtSqW+1:0]         c_dtsq3;
  logic [TiW-1:0]           c_ti_r, c_ti_nxt;

  assign c_sens_sh  = b_pc3_r >>> 8;
  assign c_off_sh   = b_pc4_r >>> 7;
  assign c_dev_sh   = b_pc6_r >>> 23;
  assign c_sens_nxt = $signed({4'b0, coeff.sens_base, 15'b0}) + $signed(c_sens_sh[SensW-1:0]);
  assign c_off_nxt  = $signed({4'b0, coeff.offset_base, 16'b0}) + $signed(c_off_sh[OffW-1:0]);
  assign c_dev_nxt  = c_dev_sh[DevW-1:0];
  assign c_cold_nxt = $signed({c_dev_nxt[DevW-1], c_dev_nxt}) + ColdW'(ColdBias);
  assign c_low_nxt  = b_pc6_r[MulW-1];
  assign c_cold_band_nxt = c_dev_nxt < DevW'(DevCold);
  assign c_dtsq3    = {2'b0, b_dtsq_r} + {1'b0, b_dtsq_r, 1'b0};
  assign c_ti_nxt   = c_low_nxt ? c_dtsq3[DtSqW+1:33] : {5'b0, b_dtsq_r[DtSqW-1:36]};

  // Stage D: squares of the deviations, final temperature.
  logic [RawW-1:0]           d_d1_r;
  logic signed [SensW-1:0]   d_sens_r;
  logic signed [OffW-1:0]    d_off_r;
  logic                      d_low_r, d_cold_band_r;
  logic signed [2*DevW-1:0]  d_dev2_full;
  logic signed [2*ColdW-1:0] d_cold2_full;
  logic [SqW-1:0]            d_dev2_r, d_cold2_r;
  logic signed [TempW+1:0]   d_temp_full;
  logic signed [TempW-1:0]   d_temp_r, d_temp_nxt;

  assign d_dev2_full  = c_dev_r * c_dev_r;
  assign d_cold2_full = c_cold_r * c_cold_r;
  assign d_temp_full  = $signed({{2{c_dev_r[DevW-1]}}, c_dev_r}) + (TempW + 2)'(TempBase)
                      - $signed({3'b0, c_ti_r});

  always_comb begin
    if (d_temp_full < TempMinL) begin
      d_temp_nxt = {1'b1, {(TempW-1){1'b0}}};
    end else if (d_temp_full > TempMaxL) begin
      d_temp_nxt = {1'b0, {(TempW-1){1'b1}}};
    end else begin
      d_temp_nxt = d_temp_full[TempW-1:0];
    end
  end

  // Stage E: second-order offset and sensitivity corrections.
  logic [RawW-1:0]          e_d1_r;
  logic signed [SensW-1:0]  e_sens_r;
  logic signed [OffW-1:0]   e_off_r;
  logic signed [TempW-1:0]  e_temp_r;
  logic [CorrW-1:0]         e_offi_low, e_cold7, e_dev5, e_sensi_low, e_cold4;
  logic [CorrW-1:0]         e_offi_r, e_offi_nxt, e_sensi_r, e_sensi_nxt;

  assign e_offi_low  = {3'b0, d_dev2_r} + {4'b0, d_dev2_r[SqW-1:1]};
  assign e_cold7     = {d_cold2_r, 3'b0} - {3'b0, d_cold2_r};
  assign e_dev5      = {1'b0, d_dev2_r, 2'b0} + {3'b0, d_dev2_r};
  assign e_sensi_low = {3'b0, e_dev5[CorrW-1:3]};
  assign e_cold4     = {1'b0, d_cold2_r, 2'b0};

  always_comb begin
    if (d_low_r) begin
      e_offi_nxt  = e_offi_low + (d_cold_band_r ? e_cold7 : '0);
      e_sensi_nxt = e_sensi_low + (d_cold_band_r ? e_cold4 : '0);
    end else begin
      e_offi_nxt  = {7'b0, d_dev2_r[SqW-1:4]};
      e_sensi_nxt = '0;
    end
  end

  // Stage F: corrected offset and sensitivity.
  ptc_mid_t f_mid_r, f_mid_nxt;

  always_comb begin
    f_mid_nxt.off2  = $signed({{(Off2W-OffW){e_off_r[OffW-1]}}, e_off_r})
                    - $signed({2'b0, e_offi_r});
    f_mid_nxt.sens2 = $signed({{(Sens2W-SensW){e_sens_r[SensW-1]}}, e_sens_r})
                    - $signed({2'b0, e_sensi_r});
    f_mid_nxt.pressure_raw = e_d1_r;
    f_mid_nxt.temp  = e_temp_r;
  end

  assign mid = f_mid_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_d1_r <= pressure_raw;
      a_dt_r <= a_dt_nxt;
    end
    if (en[1]) begin
      b_d1_r   <= a_d1_r;
      b_pc3_r  <= b_pc3_nxt;
      b_pc4_r  <= b_pc4_nxt;
      b_pc6_r  <= b_pc6_nxt;
      b_dtsq_r <= b_dtsq_full[DtSqW-1:0];
    end
    if (en[2]) begin
      c_d1_r        <= b_d1_r;
      c_sens_r      <= c_sens_nxt;
      c_off_r       <= c_off_nxt;
      c_dev_r       <= c_dev_nxt;
      c_cold_r      <= c_cold_nxt;
      c_low_r       <= c_low_nxt;
      c_cold_band_r <= c_cold_band_nxt;
      c_ti_r        <= c_ti_nxt;
    end
    if (en[3]) begin
      d_d1_r        <= c_d1_r;
      d_sens_r      <= c_sens_r;
      d_off_r       <= c_off_r;
      d_low_r       <= c_low_r;
      d_cold_band_r <= c_cold_band_r;
      d_dev2_r      <= d_dev2_full[SqW-1:0];
      d_cold2_r     <= d_cold2_full[SqW-1:0];
      d_temp_r      <= d_temp_nxt;
    end
    if (en[4]) begin
      e_d1_r    <= d_d1_r;
      e_sens_r  <= d_sens_r;
      e_off_r   <= d_off_r;
      e_temp_r  <= d_temp_r;
      e_offi_r  <= e_offi_nxt;
      e_sensi_r <= e_sensi_nxt;
    end
    if (en[5]) begin
      f_mid_r <= f_mid_nxt;
    end
  end

endmodule

// ===== rtl/ptc_press_scale.sv =====
module ptc_press_scale (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              mid_valid,
  output logic                              mid_ready,
  input  ptc_pkg::ptc_mid_t                 mid,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ptc_pkg::PressW-1:0] pressure_tenth_mbar,
  output logic signed [ptc_pkg::TempW-1:0]  temperature_centi_c
);
  import ptc_pkg::*;

  localparam int Stages = 5;
  localparam int HiW    = Sens2W - SplitW;

  logic [Stages-1:0] v_r;
  logic [Stages-1:0] en;

  always_comb begin
    en[Stages-1] = ~v_r[Stages-1] | out_ready;
    for (int k = Stages - 2; k >= 0; k--) begin
      en[k] = ~v_r[k] | en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= (v_r & ~en) | ({v_r[Stages-2:0], mid_valid} & en);
    end
  end

  assign mid_ready = en[0];
  assign out_valid = v_r[Stages-1];

  // Stage G: the pressure product is split into two partial products.
  logic [RawW+SplitW-1:0]        g_pp_lo_r, g_pp_lo_nxt;
  logic signed [RawW+HiW:0]      g_pp_hi_r, g_pp_hi_nxt;
  logic signed [Off2W-1:0]       g_off2_r;
  logic signed [TempW-1:0]       g_temp_r;

  assign g_pp_lo_nxt = mid.pressure_raw * mid.sens2[SplitW-1:0];
  assign g_pp_hi_nxt = $signed({1'b0, mid.pressure_raw}) * $signed(mid.sens2[Sens2W-1:SplitW]);

  // Stage H: recombine.
  logic signed [ProdW:0]   h_prod_full;
  logic signed [ProdW-1:0] h_prod_r;
  logic signed [Off2W-1:0] h_off2_r;
  logic signed [TempW-1:0] h_temp_r;

  assign h_prod_full = $signed({g_pp_hi_r, {SplitW{1'b0}}})
                     + $signed({{(ProdW+1-RawW-SplitW){1'b0}}, g_pp_lo_r});

  // Stage I: divide by 2^21 rounding toward zero; negative values are biased first.
  logic signed [ProdW-1:0] i_sum, i_shift;
  logic signed [QuotW-1:0] i_quot_r;
  logic signed [Off2W-1:0] i_off2_r;
  logic signed [TempW-1:0] i_temp_r;

  assign i_sum   = h_prod_r + $signed({{(ProdW-21){1'b0}}, {21{h_prod_r[ProdW-1]}}});
  assign i_shift = i_sum >>> 21;

  // Stage J: remove the offset.
  logic signed [DiffW-1:0] j_diff_r, j_diff_nxt;
  logic signed [TempW-1:0] j_temp_r;

  assign j_diff_nxt = $signed({i_quot_r[QuotW-1], i_quot_r})
                    - $signed({{(DiffW-Off2W){i_off2_r[Off2W-1]}}, i_off2_r});

  // Stage K: divide by 2^13 toward zero and saturate.
  logic signed [DiffW-1:0]  k_sum, k_shift;
  logic signed [PressW-1:0] k_press_r, k_press_nxt;
  logic signed [TempW-1:0]  k_temp_r;

  assign k_sum   = j_diff_r + $signed({{(DiffW-13){1'b0}}, {13{j_diff_r[DiffW-1]}}});
  assign k_shift = k_sum >>> 13;

  always_comb begin
    if (k_shift < PressMinL) begin
      k_press_nxt = {1'b1, {(PressW-1){1'b0}}};
    end else if (k_shift > PressMaxL) begin
      k_press_nxt = {1'b0, {(PressW-1){1'b1}}};
    end else begin
      k_press_nxt = k_shift[PressW-1:0];
    end
  end

  assign pressure_tenth_mbar = k_press_r;
  assign temperature_centi_c = k_temp_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      g_pp_lo_r <= g_pp_lo_nxt;
      g_pp_hi_r <= g_pp_hi_nxt;
      g_off2_r  <= mid.off2;
      g_temp_r  <= mid.temp;
    end
    if (en[1]) begin
      h_prod_r <= h_prod_full[ProdW-1:0];
      h_off2_r <= g_off2_r;
      h_temp_r <= g_temp_r;
    end
    if (en[2]) begin
      i_quot_r <= i_shift[QuotW-1:0];
      i_off2_r <= h_off2_r;
      i_temp_r <= h_temp_r;
    end
    if (en[3]) begin
      j_diff_r <= j_diff_nxt;
      j_temp_r <= i_temp_r;
    end
    if (en[4]) begin
      k_press_r <= k_press_nxt;
      k_temp_r  <= j_temp_r;
    end
  end

endmodule

// ===== rtl/pressure_temperature_compensation.sv =====
// Channel | Direction | Contents
// in_     | request   | tdata: pressure_raw [23:0], temperature_raw [47:24]
// out_    | result    | tdata: pressure_tenth_mbar [20:0], temperature_centi_c [38:21]
// cfg_    | write     | cfg_index selects one of six calibration words, cfg_data its value
//
// Eleven register stages; the split 25x40 pressure multiply sets the stage count.
// One request per cycle is taken while out_tready is high or some stage has room.
// Reset clears the stage valid bits and the calibration words, nothing else.
// A stalled output holds its result; each stage keeps loading while the one after it
// has room, so bubbles fill up and in_tready stays high until every stage is full.
module pressure_temperature_compensation (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // pressure_raw [23:0], temperature_raw [47:24]
  input  logic [ptc_pkg::InDataW-1:0]     in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // pressure_tenth_mbar [20:0], temperature_centi_c [38:21], zero [39]
  output logic [ptc_pkg::OutDataW-1:0]    out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ptc_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [ptc_pkg::CoefW-1:0]       cfg_data
);
  import ptc_pkg::*;

  ptc_coeff_t               coeff;
  ptc_mid_t                 mid;
  logic                     mid_valid;
  logic                     mid_ready;
  logic signed [PressW-1:0] pressure_tenth_mbar;
  logic signed [TempW-1:0]  temperature_centi_c;

  ptc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coeff     (coeff)
  );

  ptc_comp_front u_comp_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .coeff           (coeff),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .pressure_raw    (in_tdata[RawW-1:0]),
    .temperature_raw (in_tdata[2*RawW-1:RawW]),
    .mid_valid       (mid_valid),
    .mid_ready       (mid_ready),
    .mid             (mid)
  );

  ptc_press_scale u_press_scale (
    .clk                 (clk),
    .rst_n               (rst_n),
    .mid_valid           (mid_valid),
    .mid_ready           (mid_ready),
    .mid                 (mid),
    .out_valid           (out_tvalid),
    .out_ready           (out_tready),
    .pressure_tenth_mbar (pressure_tenth_mbar),
    .temperature_centi_c (temperature_centi_c)
  );

  assign out_tdata = {{(OutDataW-PressW-TempW){1'b0}}, temperature_centi_c, pressure_tenth_mbar};

endmodule

// ===== rtl/ptc_checker.sv =====
module ptc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [ptc_pkg::OutDataW-1:0]  out_tdata
);

  // The pipeline is many stages deep, so nothing can come out right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid ##1 !out_tvalid ##1 !out_tvalid)
    else $error("result appeared too soon after reset");

  // With the output free, every stage can shift, so a request must be taken.
  a_free_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tready || !out_tvalid) |-> in_tready)
    else $error("input stalled while the output side was free");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or vanished");

endmodule

bind pressure_temperature_compensation ptc_checker u_ptc_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import ptc_pkg::*;

  localparam int PipeDepth   = 10;
  localparam int DrainCycles = PipeDepth + 2;
  localparam int StallLimit  = 500;
  localparam int RandomPhases = 8;
  localparam int PerPhase     = 118;
  localparam int RawMax       = (1 << RawW) - 1;
  localparam logic [CoefW-1:0] CoefMax = '1;

  // Indexes past the last calibration word; writes to them must be dropped.
  localparam logic [CfgIdxW-1:0] SpareIdxLo = 3'd6;
  localparam logic [CfgIdxW-1:0] SpareIdxHi = 3'd7;

  // Bias and thresholds of the second-order correction, in 0.01 degC.
  localparam longint WarmLimit = TempBase;
  localparam longint ColdLimit = -1500;

  typedef struct packed {
    logic signed [TempW-1:0]  temp_centi;
    logic signed [PressW-1:0] press_tenth;
  } reading_t;

  typedef enum {STEP_WRITE, STEP_SAMPLE} step_kind_t;

  typedef struct {
    step_kind_t          kind;
    logic [CfgIdxW-1:0]  index;
    logic [CoefW-1:0]    value;
    logic [RawW-1:0]     press_raw;
    logic [RawW-1:0]     temp_raw;
    bit                  is_fixed;
    reading_t            fixed;
  } step_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [InDataW-1:0]   in_tdata   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OutDataW-1:0]  out_tdata;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CfgIdxW-1:0]   cfg_index  = '0;
  logic [CoefW-1:0]     cfg_data   = '0;

  logic [CoefW-1:0] calib [6];
  reading_t         readings [$];
  step_t            plan [$];
  int               error_count = 0;
  int               stall_left  = 0;
  bit               in_burst    = 1'b0;
  bit               out_burst   = 1'b0;

  pressure_temperature_compensation i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // First-order correction, then the second-order terms of the matching band.
  function automatic reading_t compensate(logic [RawW-1:0] praw, logic [RawW-1:0] traw);
    longint d1, d2, c1, c2, c3, c4, c5, c6;
    longint dt, sens, off, temp, dev, cold, ti, offi, sensi, p;
    reading_t r;
    d1 = praw;
    d2 = traw;
    c1 = calib[REG_SENS_BASE];
    c2 = calib[REG_OFFSET_BASE];
    c3 = calib[REG_SENS_TEMP];
    c4 = calib[REG_OFFSET_TEMP];
    c5 = calib[REG_REF_TEMP];
    c6 = calib[REG_TEMP_SLOPE];
    dt   = d2 - c5 * 256;
    sens = c1 * 32768 + ((c3 * dt) >>> 8);
    off  = c2 * 65536 + ((c4 * dt) >>> 7);
    temp = WarmLimit + ((dt * c6) >>> 23);
    dev  = temp - WarmLimit;
    if (temp < WarmLimit) begin
      ti    = (3 * dt * dt) >>> 33;
      offi  = (3 * dev * dev) / 2;
      sensi = (5 * dev * dev) / 8;
      if (temp < ColdLimit) begin
        cold  = temp - ColdLimit;
        offi  = offi + 7 * cold * cold;
        sensi = sensi + 4 * cold * cold;
      end
    end else begin
      ti    = (2 * dt * dt) >>> 37;
      offi  = (dev * dev) / 16;
      sensi = 0;
    end
    temp = temp - ti;
    // Both divisions truncate toward zero, as signed division does here.
    p = ((d1 * (sens - sensi)) / 2097152 - (off - offi)) / 8192;
    if (p < PressMinL) p = PressMinL;
    if (p > PressMaxL) p = PressMaxL;
    if (temp < TempMinL) temp = TempMinL;
    if (temp > TempMaxL) temp = TempMaxL;
    r.press_tenth = p[PressW-1:0];
    r.temp_centi  = temp[TempW-1:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [CoefW-1:0] pick_coeff();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CoefMax;
      default: return CoefW'($urandom);
    endcase
  endfunction

  function automatic void add_write(logic [CfgIdxW-1:0] index, logic [CoefW-1:0] value);
    step_t s;
    s = '{kind: STEP_WRITE, default: '0};
    s.kind  = STEP_WRITE;
    s.index = index;
    s.value = value;
    plan.push_back(s);
  endfunction

  function automatic void add_sample(logic [RawW-1:0] praw, logic [RawW-1:0] traw);
    step_t s;
    s = '{kind: STEP_SAMPLE, default: '0};
    s.kind      = STEP_SAMPLE;
    s.press_raw = praw;
    s.temp_raw  = traw;
    plan.push_back(s);
  endfunction

  function automatic void add_checked(logic [RawW-1:0] praw, logic [RawW-1:0] traw,
                                      int press, int temp);
    step_t s;
    s = '{kind: STEP_SAMPLE, default: '0};
    s.kind              = STEP_SAMPLE;
    s.press_raw         = praw;
    s.temp_raw          = traw;
    s.is_fixed          = 1'b1;
    s.fixed.press_tenth = press[PressW-1:0];
    s.fixed.temp_centi  = temp[TempW-1:0];
    plan.push_back(s);
  endfunction

  task automatic flag_error(input string what, input reading_t want, input reading_t got);
    if (error_count < 10)
      $display("%0t: %s: expected p=%0d t=%0d, got p=%0d t=%0d", $time, what,
               want.press_tenth, want.temp_centi, got.press_tenth, got.temp_centi);
    error_count++;
  endtask

  // Raises the write request and leaves it up; the caller lowers it.
  task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [CoefW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (index <= REG_TEMP_SLOPE) calib[index] = value;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (readings.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic send_sample(input logic [RawW-1:0] praw, input logic [RawW-1:0] traw,
                             input bit is_fixed, input reading_t fixed);
    int gap;
    cfg_valid <= 1'b0;
    gap = in_burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {traw, praw};
    do @(posedge clk); while (!in_tready);
    readings.push_back(is_fixed ? fixed : compensate(praw, traw));
  endtask

  function automatic logic [RawW-1:0] random_temp_raw();
    int v;
    int base;
    base = int'(calib[REG_REF_TEMP]) * 256;
    case ($urandom_range(0, 2))
      0: v = $urandom_range(0, RawMax);
      1: v = base + int'($urandom_range(0, 131071)) - 65536;
      default: v = base + int'($urandom_range(0, 4194303)) - 2097152;
    endcase
    if (v < 0) v = 0;
    if (v > RawMax) v = RawMax;
    return v[RawW-1:0];
  endfunction

  function automatic logic [RawW-1:0] random_press_raw();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return RawW'(RawMax);
      default: return RawW'($urandom_range(0, RawMax));
    endcase
  endfunction

  always @(posedge clk) begin : result_check
    reading_t got;
    reading_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = reading_t'(out_tdata[PressW+TempW-1:0]);
      if (readings.size() == 0) begin
        flag_error("result with no request pending", '0, got);
      end else begin
        want = readings.pop_front();
        if (got.press_tenth !== want.press_tenth || got.temp_centi !== want.temp_centi)
          flag_error("wrong reading", want, got);
      end
    end
    if ($urandom_range(0, 199) == 0) out_burst = !out_burst;
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      if (!out_burst && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < StallLimit) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    bit       samples_sent;
    reading_t none;
    foreach (calib[k]) calib[k] = '0;
    none = '0;
    samples_sent = 1'b0;

    // Calibration words all zero after reset: pressure is zero, temperature only
    // carries the warm-band square term.
    add_checked(0, 0, 0, 2000);
    add_checked(RawW'(RawMax), 0, 0, 2000);
    add_checked(0, RawW'(RawMax), 0, -2095);
    add_checked(RawW'(RawMax), RawW'(RawMax), 0, -2095);
    // Full sensitivity at zero dt drives pressure to its upper limit.
    add_write(REG_SENS_BASE, CoefMax);
    add_checked(RawW'(RawMax), 0, 1048575, 2000);
    // Far below the reference with the steepest slope: both fields clamp low.
    add_write(REG_SENS_BASE, '0);
    add_write(REG_REF_TEMP, CoefMax);
    add_write(REG_TEMP_SLOPE, CoefMax);
    add_write(SpareIdxLo, 16'h1234);
    add_write(SpareIdxHi, CoefMax);
    add_checked(RawW'(RawMax), 0, -1048576, -131072);
    add_sample(0, 0);
    add_sample(RawW'(RawMax), RawW'(RawMax));
    // A typical calibration, walking the temperature bands around the reference.
    add_write(REG_SENS_BASE, 16'd34982);
    add_write(REG_OFFSET_BASE, 16'd36352);
    add_write(REG_SENS_TEMP, 16'd20328);
    add_write(REG_OFFSET_TEMP, 16'd22354);
    add_write(REG_REF_TEMP, 16'd26646);
    add_write(REG_TEMP_SLOPE, 16'd26146);
    add_write(SpareIdxLo, '0);
    add_sample(24'd4958179, 24'd6815414);
    add_sample(24'd4958179, 24'd6821376);
    add_sample(24'd4958179, 24'd6821375);
    add_sample(24'd4958179, 24'd5000000);
    add_sample(24'd4958179, 24'd0);
    add_sample(24'd4958179, RawW'(RawMax));
    add_sample(0, 24'd5698000);
    add_sample(RawW'(RawMax), 24'd6900000);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[k]) begin
      if (plan[k].kind == STEP_WRITE) begin
        if (samples_sent) begin
          drain();
          samples_sent = 1'b0;
        end
        write_reg(plan[k].index, plan[k].value);
      end else begin
        send_sample(plan[k].press_raw, plan[k].temp_raw, plan[k].is_fixed, plan[k].fixed);
        samples_sent = 1'b1;
      end
    end

    for (int ph = 0; ph < RandomPhases; ph++) begin
      drain();
      if ($urandom_range(0, 1) == 1)
        write_reg(CfgIdxW'(SpareIdxLo + $urandom_range(0, 1)), pick_coeff());
      write_reg(REG_SENS_BASE, pick_coeff());
      write_reg(REG_OFFSET_BASE, pick_coeff());
      write_reg(REG_SENS_TEMP, pick_coeff());
      write_reg(REG_OFFSET_TEMP, pick_coeff());
      write_reg(REG_REF_TEMP, pick_coeff());
      write_reg(REG_TEMP_SLOPE, pick_coeff());
      for (int n = 0; n < PerPhase; n++) begin
        if ($urandom_range(0, 63) == 0) in_burst = !in_burst;
        // Now and then hold off until the pipeline has emptied completely.
        if ($urandom_range(0, 59) == 0) drain();
        send_sample(random_press_raw(), random_temp_raw(), 1'b0, none);
      end
    end

    in_tvalid <= 1'b0;
    while (readings.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0 && readings.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
